### rtl/ground_mask_median_fraction_macros.svh
// ----------------------------------------------------------------------------
// ground_mask_median_fraction_macros
// assertion macros shared by the checker file
// ----------------------------------------------------------------------------
`ifndef GROUND_MASK_MEDIAN_FRACTION_MACROS_SVH
`define GROUND_MASK_MEDIAN_FRACTION_MACROS_SVH

// concurrent check, off while reset is low
`define GMMF_ASSERT(label, ck, rn, prop, msg) \
  label: assert property (@(posedge ck) disable iff (!(rn)) prop) else $error(msg);

// concurrent check that also runs during reset
`define GMMF_ASSERT_RST(label, ck, prop, msg) \
  label: assert property (@(posedge ck) prop) else $error(msg);

`endif

### rtl/gmmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmmf_pkg
// shared types, register indexes and widths of the ground mask block
// ----------------------------------------------------------------------------
package gmmf_pkg;

  localparam int IN_W    = 32;
  localparam int OUT_W   = 24;
  localparam int CFG_W   = 17;
  localparam int COUNT_W = 19;
  localparam int THR_W   = 17;
  localparam int DIM_W   = 10;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t REG_FRAME_WIDTH   = 2'd0;
  localparam cfg_index_t REG_FRAME_HEIGHT  = 2'd1;
  localparam cfg_index_t REG_MEDIAN_ENABLE = 2'd2;
  localparam cfg_index_t REG_THRESHOLD_Q16 = 2'd3;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 10'd512;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 10'd512;
  localparam logic             MEDIAN_EN_RST    = 1'b1;
  localparam logic [THR_W-1:0] THRESHOLD_RST    = 17'd3277;

  // class bits of one macro-pixel, left pixel in raw0
  typedef struct packed {
    logic raw1;
    logic raw0;
  } cls_pair_t;

  // frame total handed to the threshold pipe
  typedef struct packed {
    logic               valid;
    logic [COUNT_W-1:0] count;
  } frame_res_t;

  // bits to hold 0..n, at least two
  function automatic int cnt_bits(input int n);
    int b;
    b = $clog2(n + 1);
    return (b < 2) ? 2 : b;
  endfunction

endpackage

### rtl/ground_mask_median_fraction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ground_mask_median_fraction
// counts ground pixels of a UYVY frame and flags the ground fraction
// ----------------------------------------------------------------------------
// in_*  : one macro-pixel per transfer in raster order, tdata = u, y0, v, y1
//         from the low byte up; the frame shape comes from the registers.
// out_* : one transfer per frame after its last macro-pixel, tdata bit 0 is
//         ground_found, bits 19:1 ground_count.
// cfg_* : frame_width, frame_height, median_enable, threshold_q16 at indexes
//         0 to 3; the user must write them only between frames, not enforced.
// Throughput is one macro-pixel per clock while the output is not stalled:
// each item does one read and one write of the two-bit line store entry
// pair and one window update. A frame's last item passes through the queue,
// the window stage and two multiply stages into the output register.
// A stalled output register holds the result and freezes the back end; the
// four entry queue keeps taking input until it fills, then in_tready drops.
// Reset clears counters, the total, the queue and the output and restores
// the register defaults; the line store is not cleared.
// ----------------------------------------------------------------------------
module ground_mask_median_fraction #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [31:0]            in_tdata,    // u, y0, v, y1
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [23:0]            out_tdata,   // ground_found, ground_count
  input  logic                   cfg_we,
  input  gmmf_pkg::cfg_index_t   cfg_index,
  input  logic [16:0]            cfg_wdata
);

  localparam int WB        = gmmf_pkg::cnt_bits(MAX_WIDTH);
  localparam int HB        = gmmf_pkg::cnt_bits(MAX_HEIGHT);
  localparam int MAXW_EVEN = (MAX_WIDTH / 2) * 2;

  logic [gmmf_pkg::DIM_W-1:0] frame_width_r, frame_height_r;
  logic                       median_en_r;
  logic [gmmf_pkg::THR_W-1:0] threshold_r;
  logic [gmmf_pkg::DIM_W-1:0] w_even;
  logic [WB-1:0]              frame_w;
  logic [HB-1:0]              frame_h;

  logic                       q_pop, q_valid, adv;
  gmmf_pkg::cls_pair_t        q_item;
  gmmf_pkg::frame_res_t       res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= gmmf_pkg::FRAME_WIDTH_RST;
      frame_height_r <= gmmf_pkg::FRAME_HEIGHT_RST;
      median_en_r    <= gmmf_pkg::MEDIAN_EN_RST;
      threshold_r    <= gmmf_pkg::THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gmmf_pkg::REG_FRAME_WIDTH:   frame_width_r  <= cfg_wdata[gmmf_pkg::DIM_W-1:0];
        gmmf_pkg::REG_FRAME_HEIGHT:  frame_height_r <= cfg_wdata[gmmf_pkg::DIM_W-1:0];
        gmmf_pkg::REG_MEDIAN_ENABLE: median_en_r    <= cfg_wdata[0];
        gmmf_pkg::REG_THRESHOLD_Q16: threshold_r    <= cfg_wdata[gmmf_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame shape: even width, both clamped to the store limits
  assign w_even = {frame_width_r[gmmf_pkg::DIM_W-1:1], 1'b0};

  always_comb begin
    if ({22'd0, w_even} > 32'(MAXW_EVEN)) begin
      frame_w = WB'(MAXW_EVEN);
    end else if (w_even < 10'd2) begin
      frame_w = WB'(2);
    end else begin
      frame_w = WB'(w_even);
    end
    if ({22'd0, frame_height_r} > 32'(MAX_HEIGHT)) begin
      frame_h = HB'(MAX_HEIGHT);
    end else if (frame_height_r == '0) begin
      frame_h = HB'(1);
    end else begin
      frame_h = HB'(frame_height_r);
    end
  end

  gmmf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_pop     (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  gmmf_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .adv       (adv),
    .frame_w   (frame_w),
    .frame_h   (frame_h),
    .median_en (median_en_r),
    .res       (res)
  );

  gmmf_result #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_result (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .frame_w    (frame_w),
    .frame_h    (frame_h),
    .thr        (threshold_r),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### rtl/gmmf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmmf_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module gmmf_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/gmmf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmmf_front
// input side: classifies both pixels of a macro-pixel and queues the bits
// ----------------------------------------------------------------------------
module gmmf_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [31:0]            in_tdata,   // u, y0, v, y1
  input  logic                   q_pop,
  output logic                   q_valid,
  output gmmf_pkg::cls_pair_t    q_item
);

  localparam int CW = gmmf_pkg::QUEUE_AW + 1;

  localparam logic [7:0] U_SPLIT   = 8'd115;
  localparam logic [7:0] V_LOW     = 8'd145;
  localparam logic [7:0] Y_LOW     = 8'd85;
  localparam logic [7:0] U_FLOOR   = 8'd92;
  localparam logic [7:0] V_MID     = 8'd152;
  localparam logic [7:0] Y_CEIL    = 8'd177;
  localparam logic [7:0] U_HIGH    = 8'd121;
  localparam logic [7:0] V_HIGH    = 8'd137;
  localparam logic [7:0] Y_HIGH    = 8'd87;

  function automatic logic classify(input logic [7:0] y, input logic [7:0] u,
                                    input logic [7:0] v);
    logic g;
    g = 1'b0;
    if (u <= U_SPLIT) begin
      if (v <= V_LOW) begin
        g = (y > Y_LOW) && (u > U_FLOOR);
      end else if (v <= V_MID) begin
        g = (y <= Y_CEIL);
      end
    end else if ((u <= U_HIGH) && (v <= V_HIGH)) begin
      g = (y > Y_HIGH);
    end
    return g;
  endfunction

  logic [7:0]                  u_in, y0_in, v_in, y1_in;
  gmmf_pkg::cls_pair_t         push_item;
  logic                        push;
  gmmf_pkg::cls_pair_t         mem_r [gmmf_pkg::QUEUE_DEPTH];
  logic [gmmf_pkg::QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]               cnt_r;

  assign u_in  = in_tdata[7:0];
  assign y0_in = in_tdata[15:8];
  assign v_in  = in_tdata[23:16];
  assign y1_in = in_tdata[31:24];

  assign push_item.raw0 = classify(y0_in, u_in, v_in);
  assign push_item.raw1 = classify(y1_in, u_in, v_in);

  assign in_tready = (cnt_r != CW'(gmmf_pkg::QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_item    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && q_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### rtl/gmmf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmmf_back
// raster counters, line store, 3x3 window majority and ground total
// ----------------------------------------------------------------------------
module gmmf_back #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     q_valid,
  input  gmmf_pkg::cls_pair_t                      q_item,
  output logic                                     q_pop,
  input  logic                                     adv,
  input  logic [gmmf_pkg::cnt_bits(MAX_WIDTH)-1:0]  frame_w,
  input  logic [gmmf_pkg::cnt_bits(MAX_HEIGHT)-1:0] frame_h,
  input  logic                                     median_en,
  output gmmf_pkg::frame_res_t                     res
);

  localparam int WB    = gmmf_pkg::cnt_bits(MAX_WIDTH);
  localparam int HB    = gmmf_pkg::cnt_bits(MAX_HEIGHT);
  localparam int PAIRS = MAX_WIDTH / 2;
  localparam int PB    = $clog2(PAIRS);
  localparam int CW    = gmmf_pkg::COUNT_W;

  function automatic logic [3:0] count_ones(input logic [8:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 9; i++) begin
      n = n + 4'(b[i]);
    end
    return n;
  endfunction

  logic [PB-1:0]        pc_r;
  logic [HB-1:0]        row_r;
  logic [WB-1:0]        xw;
  logic                 col_last, row_last;

  logic                 a_valid_r;
  gmmf_pkg::cls_pair_t  a_cls_r;
  logic [PB-1:0]        a_pc_r;
  logic [HB-1:0]        a_row_r;
  logic                 a_last_r;
  logic                 a_ret;

  logic                 fwd_r;
  logic [3:0]           fwd_data_r;
  logic [3:0]           ram_q;
  logic [3:0]           old;
  logic [3:0]           wdata;

  logic [8:0]           win_r;
  logic [8:0]           wbase, w1, w2;
  logic [2:0]           c0, c1;
  logic [CW-1:0]        total_r;
  logic [CW-1:0]        tot_sat;
  logic [CW:0]          sum;
  logic [2:0]           inc;

  logic [WB-1:0]        ax, ax1, wm1;
  logic [HB-1:0]        hm1;
  logic                 row_edge, row_ok;
  logic                 border0, border1, col_ok0, col_ok1;
  logic                 add_raw0, add_raw1, add_med0, add_med1;

  // queue head: raster position of the next macro-pixel
  assign xw       = WB'({pc_r, 1'b0});
  assign col_last = (xw >= frame_w - WB'(2));
  assign row_last = (row_r >= frame_h - HB'(1));
  assign q_pop    = adv && q_valid;
  assign a_ret    = a_valid_r && adv;

  gmmf_ram #(
    .WIDTH (4),
    .DEPTH (PAIRS)
  ) u_line (
    .clk   (clk),
    .we    (a_ret),
    .waddr (a_pc_r),
    .wdata (wdata),
    .re    (q_pop),
    .raddr (pc_r),
    .rdata (ram_q)
  );

  always_comb begin
    old   = fwd_r ? fwd_data_r : ram_q;
    c0    = {old[1], old[0], a_cls_r.raw0};
    c1    = {old[3], old[2], a_cls_r.raw1};
    wdata = {old[2], a_cls_r.raw1, old[0], a_cls_r.raw0};

    ax    = WB'({a_pc_r, 1'b0});
    wbase = (ax == '0) ? 9'd0 : win_r;
    w1    = {wbase[5:0], c0};
    w2    = {wbase[2:0], c0, c1};

    ax1      = ax + WB'(1);
    wm1      = frame_w - WB'(1);
    hm1      = frame_h - HB'(1);
    row_edge = (a_row_r == '0) || (a_row_r >= hm1);
    border0  = row_edge || (ax == '0) || (ax >= wm1);
    border1  = row_edge || (ax1 == '0) || (ax1 >= wm1);
    row_ok   = (a_row_r >= HB'(2)) && (a_row_r <= hm1);
    col_ok0  = (ax >= WB'(2)) && (ax <= wm1);
    col_ok1  = (ax1 >= WB'(2)) && (ax1 <= wm1);

    add_raw0 = (!median_en || border0) && a_cls_r.raw0;
    add_raw1 = (!median_en || border1) && a_cls_r.raw1;
    add_med0 = median_en && row_ok && col_ok0 && (count_ones(w1) >= 4'd5);
    add_med1 = median_en && row_ok && col_ok1 && (count_ones(w2) >= 4'd5);

    inc     = 3'(add_raw0) + 3'(add_med0) + 3'(add_raw1) + 3'(add_med1);
    sum     = {1'b0, total_r} + (CW + 1)'(inc);
    tot_sat = (sum > {1'b0, gmmf_pkg::COUNT_MAX}) ? gmmf_pkg::COUNT_MAX : sum[CW-1:0];
  end

  assign res.valid = a_ret && a_last_r;
  assign res.count = tot_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      pc_r      <= '0;
      row_r     <= '0;
      win_r     <= '0;
      total_r   <= '0;
    end else begin
      if (adv) begin
        a_valid_r <= q_valid;
      end
      if (q_pop) begin
        if (!col_last) begin
          pc_r <= pc_r + 1'b1;
        end else begin
          pc_r <= '0;
          if (!row_last) begin
            row_r <= row_r + 1'b1;
          end else begin
            row_r <= '0;
          end
        end
      end
      if (a_ret) begin
        if (a_last_r) begin
          total_r <= '0;
          win_r   <= '0;
        end else begin
          total_r <= tot_sat;
          win_r   <= w2;
        end
      end
    end
  end

  // stage payload, with bypass of the entry written in the same cycle
  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_cls_r    <= q_item;
      a_pc_r     <= pc_r;
      a_row_r    <= row_r;
      a_last_r   <= col_last && row_last;
      fwd_r      <= a_ret && (a_pc_r == pc_r);
      fwd_data_r <= wdata;
    end
  end

endmodule

### rtl/gmmf_result.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmmf_result
// threshold product pipe, fraction compare and output register
// ----------------------------------------------------------------------------
module gmmf_result #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  gmmf_pkg::frame_res_t                     res,
  input  logic [gmmf_pkg::cnt_bits(MAX_WIDTH)-1:0]  frame_w,
  input  logic [gmmf_pkg::cnt_bits(MAX_HEIGHT)-1:0] frame_h,
  input  logic [gmmf_pkg::THR_W-1:0]               thr,
  output logic                                     adv,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  output logic [23:0]                              out_tdata   // ground_found, ground_count
);

  localparam int WB  = gmmf_pkg::cnt_bits(MAX_WIDTH);
  localparam int HB  = gmmf_pkg::cnt_bits(MAX_HEIGHT);
  localparam int CNW = gmmf_pkg::COUNT_W;
  localparam int P1W = gmmf_pkg::THR_W + WB;
  localparam int P2W = P1W + HB;
  localparam int LW  = CNW + 16;
  localparam int CPW = (P2W > LW) ? P2W : LW;

  logic             m1_valid_r, m2_valid_r, out_valid_r;
  logic [CNW-1:0]   m1_cnt_r, m2_cnt_r, out_cnt_r;
  logic [P1W-1:0]   m1_p_r, p1_nxt;
  logic [P2W-1:0]   m2_p_r, p2_nxt;
  logic [CPW-1:0]   lhs, rhs;
  logic             out_found_r;

  assign adv    = !out_valid_r || out_tready;
  assign p1_nxt = P1W'(thr) * P1W'(frame_w);
  assign p2_nxt = P2W'(m1_p_r) * P2W'(frame_h);
  assign lhs    = CPW'({m2_cnt_r, 16'd0});
  assign rhs    = CPW'(m2_p_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r  <= 1'b0;
      m2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      m1_valid_r  <= res.valid;
      m2_valid_r  <= m1_valid_r;
      out_valid_r <= m2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_cnt_r    <= res.count;
      m1_p_r      <= p1_nxt;
      m2_cnt_r    <= m1_cnt_r;
      m2_p_r      <= p2_nxt;
      out_cnt_r   <= m2_cnt_r;
      out_found_r <= (lhs > rhs);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_cnt_r, out_found_r};

endmodule

### rtl/gmmf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmmf_checker
// port level checks of the ground mask block, bound to the top level
// ----------------------------------------------------------------------------
`include "ground_mask_median_fraction_macros.svh"

module gmmf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // stalled result transfer keeps its data
  `GMMF_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")
  // fraction above threshold needs at least one ground pixel
  `GMMF_ASSERT(a_found_count, clk, rst_n, out_tvalid && out_tdata[0] |-> out_tdata[19:1] != 19'd0, "ground_found with zero count")
  `GMMF_ASSERT_RST(a_rst_out, clk, !rst_n |=> !out_tvalid, "result pending after reset")
  `GMMF_ASSERT_RST(a_rst_in, clk, !rst_n |=> in_tready, "input not ready after reset")

endmodule

bind ground_mask_median_fraction gmmf_checker u_gmmf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
